/* hdl/point_in_polygon_crossing_core_macros.svh */
// Assertion macros shared by the point-in-polygon checker.
`ifndef POINT_IN_POLYGON_CROSSING_CORE_MACROS_SVH
`define POINT_IN_POLYGON_CROSSING_CORE_MACROS_SVH

// Property checked on every clock edge outside reset.
`define PIPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define PIPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/pipc_pkg.sv */
// Shared constants and types of the point-in-polygon crossing core.
package pipc_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int RAY_END_RESET   = 30000;
  localparam int MIN_VERTICES    = 3;

  // Edge slots of an item, at most both used: the incoming edge and the closing edge
  localparam int NUM_EDGES    = 2;
  localparam int CRD_PER_EDGE = 4;

  // Coordinate slots of a job, relative to the start of an edge
  localparam int CRD_AX  = 0;
  localparam int CRD_AY  = 1;
  localparam int CRD_BX  = 2;
  localparam int CRD_BY  = 3;
  // Query point slots
  localparam int CRD_QX  = NUM_EDGES * CRD_PER_EDGE;
  localparam int CRD_QY  = CRD_QX + 1;
  localparam int NUM_CRD = CRD_QY + 1;

  // Result tdata layout
  localparam int OUT_TDATA_W     = 8;
  localparam int OUT_INSIDE_BIT  = 0;
  localparam int OUT_TOO_FEW_BIT = 1;

  // Job flags passed from front to back
  typedef struct packed {
    logic [NUM_EDGES-1:0] edge_vld;
    logic                 last;
    logic                 too_few;
  } pipc_flags_t;

endpackage

/* hdl/point_in_polygon_crossing_core.sv */
// Point-in-polygon test by ray casting over a stream of polygon vertices.
// Throughput: one vertex item per cycle while the queue has room; the back
// end tests both the incoming and the closing edge of an item at once, with
// six orientation products. The in_tlast item passes the job queue, stage 1
// and the result register. Reset: synchronous active low; clears the queue,
// pipeline and polygon state, and loads ray_end_x with 30000.
module point_in_polygon_crossing_core #(
  parameter int COORD_WIDTH = pipc_pkg::COORD_WIDTH_DEF,
  parameter int QUEUE_DEPTH = pipc_pkg::QUEUE_DEPTH_DEF,
  localparam int IN_W = ((4 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [COORD_WIDTH-1:0]           cfg_wdata,    // ray_end_x
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [IN_W-1:0]                  in_tdata,     // vertex_x, vertex_y, point_x, point_y
  input  logic                             in_tlast,     // last_vertex
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [pipc_pkg::OUT_TDATA_W-1:0] out_tdata     // inside_res, too_few_vertices
);
  import pipc_pkg::*;

  localparam int CW     = COORD_WIDTH;
  localparam int DATA_W = NUM_CRD * CW + $bits(pipc_flags_t);

  logic [NUM_CRD-1:0][CW-1:0] f_crd, b_crd;
  pipc_flags_t                f_flags, b_flags;
  logic                       f_valid, f_ready, b_valid, b_ready;
  logic [DATA_W-1:0]          q_rd_data;
  logic                       res_inside, res_too_few;

  // Front end
  pipc_front #(.CW(CW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_vx     (in_tdata[0 * CW +: CW]),
    .in_vy     (in_tdata[1 * CW +: CW]),
    .in_px     (in_tdata[2 * CW +: CW]),
    .in_py     (in_tdata[3 * CW +: CW]),
    .in_last   (in_tlast),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job_crd   (f_crd),
    .job_flags (f_flags)
  );

  // Job queue
  pipc_fifo #(.DATA_W(DATA_W), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  ({f_flags, f_crd}),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (q_rd_data)
  );

  assign {b_flags, b_crd} = q_rd_data;

  // Back end
  pipc_back #(.CW(CW)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .job_valid   (b_valid),
    .job_ready   (b_ready),
    .job_crd     (b_crd),
    .job_flags   (b_flags),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .res_inside  (res_inside),
    .res_too_few (res_too_few)
  );

  // Result packing
  always_comb begin
    out_tdata                  = '0;
    out_tdata[OUT_INSIDE_BIT]  = res_inside;
    out_tdata[OUT_TOO_FEW_BIT] = res_too_few;
  end

endmodule

/* hdl/pipc_front.sv */
// Front end: tracks the polygon walk and turns each vertex item into an edge job.
module pipc_front #(
  parameter int CW = 16
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic [CW-1:0]                             in_vx,
  input  logic [CW-1:0]                             in_vy,
  input  logic [CW-1:0]                             in_px,
  input  logic [CW-1:0]                             in_py,
  input  logic                                      in_last,
  output logic                                      job_valid,
  input  logic                                      job_ready,
  output logic [pipc_pkg::NUM_CRD-1:0][CW-1:0]      job_crd,
  output pipc_pkg::pipc_flags_t                     job_flags
);
  import pipc_pkg::*;

  localparam int TW = $clog2(MIN_VERTICES + 1);
  localparam logic [TW-1:0] TALLY_MAX = TW'(MIN_VERTICES);

  logic [TW-1:0] tally_r, tally_nxt, tally_inc;
  logic [CW-1:0] first_vx_r, first_vy_r, prev_vx_r, prev_vy_r, qx_r, qy_r;
  logic [CW-1:0] fx, fy, qx, qy;
  logic          tally_zero, accept;

  assign in_ready  = job_ready;
  assign job_valid = in_valid;
  assign accept    = in_valid && job_ready;

  // Polygon start takes the first vertex and query point from the item itself
  always_comb begin
    tally_zero = (tally_r == '0);
    tally_inc  = (tally_r == TALLY_MAX) ? tally_r : tally_r + TW'(1);
    fx         = tally_zero ? in_vx : first_vx_r;
    fy         = tally_zero ? in_vy : first_vy_r;
    qx         = tally_zero ? in_px : qx_r;
    qy         = tally_zero ? in_py : qy_r;
    tally_nxt  = in_last ? '0 : tally_inc;
  end

  // Build the job: incoming edge, closing edge, query point
  always_comb begin
    job_crd                         = '0;
    job_crd[CRD_AX]                 = prev_vx_r;
    job_crd[CRD_AY]                 = prev_vy_r;
    job_crd[CRD_BX]                 = in_vx;
    job_crd[CRD_BY]                 = in_vy;
    job_crd[CRD_PER_EDGE + CRD_AX]  = in_vx;
    job_crd[CRD_PER_EDGE + CRD_AY]  = in_vy;
    job_crd[CRD_PER_EDGE + CRD_BX]  = fx;
    job_crd[CRD_PER_EDGE + CRD_BY]  = fy;
    job_crd[CRD_QX]                 = qx;
    job_crd[CRD_QY]                 = qy;
    job_flags.edge_vld              = {in_last, !tally_zero};
    job_flags.last                  = in_last;
    job_flags.too_few               = (tally_inc < TALLY_MAX);
  end

  // Vertex count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tally_r <= '0;
    end else if (accept) begin
      tally_r <= tally_nxt;
    end
  end

  // Vertex and query point registers
  always_ff @(posedge clk) begin
    if (accept) begin
      prev_vx_r <= in_vx;
      prev_vy_r <= in_vy;
      if (tally_zero) begin
        first_vx_r <= in_vx;
        first_vy_r <= in_vy;
        qx_r       <= in_px;
        qy_r       <= in_py;
      end
    end
  end

endmodule

/* hdl/pipc_fifo.sv */
// Small job queue between front and back end.
module pipc_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  logic [DATA_W-1:0] wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output logic [DATA_W-1:0] rd_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [AW:0]   FULL_CNT = (AW + 1)'(DEPTH);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [AW-1:0]     wptr_r, rptr_r;
  logic [AW:0]       count_r;
  logic              push, pop;

  assign wr_ready = (count_r != FULL_CNT);
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem[rptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= wr_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == LAST_PTR) ? '0 : wptr_r + AW'(1);
      end
      if (pop) begin
        rptr_r <= (rptr_r == LAST_PTR) ? '0 : rptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (AW + 1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (AW + 1)'(1);
      end
    end
  end

endmodule

/* hdl/pipc_back.sv */
// Back end: edge crossing tests, parity tracking and the result register.
module pipc_back #(
  parameter int CW = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [CW-1:0]                        cfg_wdata,
  input  logic                                 job_valid,
  output logic                                 job_ready,
  input  logic [pipc_pkg::NUM_CRD-1:0][CW-1:0] job_crd,
  input  pipc_pkg::pipc_flags_t                job_flags,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output logic                                 res_inside,
  output logic                                 res_too_few
);
  import pipc_pkg::*;

  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;
  localparam logic [31:0] RAY_RST_FULL = 32'(RAY_END_RESET);

  function automatic logic btw(input logic signed [CW-1:0] v,
                               input logic signed [CW-1:0] e0,
                               input logic signed [CW-1:0] e1);
    return ((e0 <= v) && (v <= e1)) || ((e1 <= v) && (v <= e0));
  endfunction

  logic signed [CW-1:0] ray_r;

  // Stage 1 signals
  logic signed [CW-1:0] ax, ay, bx, by, qx, qy;
  logic signed [DW-1:0] dy_ba, dx_qb, dx_ba, dy_qb, dx_rb;
  logic signed [PW-1:0] p1_c [NUM_EDGES];
  logic signed [PW-1:0] p2_c [NUM_EDGES];
  logic signed [PW-1:0] pq_c [NUM_EDGES];
  logic signed [PW-1:0] p1_r [NUM_EDGES];
  logic signed [PW-1:0] p2_r [NUM_EDGES];
  logic signed [PW-1:0] pq_r [NUM_EDGES];
  logic [NUM_EDGES-1:0] wq_c, wd_c, wa_c, wb_c, o3z_c, o3n_c, o4z_c, o4n_c;
  logic [NUM_EDGES-1:0] wq_r, wd_r, wa_r, wb_r, o3z_r, o3n_r, o4z_r, o4n_r;
  logic                 rz, rn;
  pipc_flags_t          s1_flags_r;
  logic                 s1_vld_r;

  // Stage 2 signals
  logic signed [SW-1:0] d1, d2;
  logic [NUM_EDGES-1:0] o1z, o1n, o2z, o2n, meet;
  logic                 dec_r, val_r, par_r;
  logic                 dec, val, par;
  logic                 adv, s1_en, s2_fire;
  logic                 out_vld_r, out_inside_r, out_too_few_r;

  assign adv       = !out_vld_r || res_ready;
  assign s1_en     = !s1_vld_r || adv;
  assign s2_fire   = s1_vld_r && adv;
  assign job_ready = s1_en;

  // Ray end register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ray_r <= RAY_RST_FULL[CW-1:0];
    end else if (cfg_we) begin
      ray_r <= cfg_wdata;
    end
  end

  // Stage 1: orientation products and bounding box tests per edge
  always_comb begin
    qx = $signed(job_crd[CRD_QX]);
    qy = $signed(job_crd[CRD_QY]);
    rz = (ray_r == qx);
    rn = (ray_r < qx);
    for (int e = 0; e < NUM_EDGES; e++) begin
      ax = $signed(job_crd[e * CRD_PER_EDGE + CRD_AX]);
      ay = $signed(job_crd[e * CRD_PER_EDGE + CRD_AY]);
      bx = $signed(job_crd[e * CRD_PER_EDGE + CRD_BX]);
      by = $signed(job_crd[e * CRD_PER_EDGE + CRD_BY]);
      dy_ba = DW'(by) - DW'(ay);
      dx_qb = DW'(qx) - DW'(bx);
      dx_ba = DW'(bx) - DW'(ax);
      dy_qb = DW'(qy) - DW'(by);
      dx_rb = DW'(ray_r) - DW'(bx);
      // orient(a,b,q) and orient(a,b,ray end) share the second product
      p1_c[e] = dy_ba * dx_qb;
      p2_c[e] = dy_ba * dx_rb;
      pq_c[e] = dx_ba * dy_qb;
      wq_c[e] = btw(qx, ax, bx) && btw(qy, ay, by);
      wd_c[e] = btw(ray_r, ax, bx) && btw(qy, ay, by);
      wa_c[e] = btw(ax, qx, ray_r) && (ay == qy);
      wb_c[e] = btw(bx, qx, ray_r) && (by == qy);
      // Ray is horizontal: its orientations reduce to sign products
      o3z_c[e] = rz || (ay == qy);
      o3n_c[e] = !o3z_c[e] && (rn == (ay < qy));
      o4z_c[e] = rz || (by == qy);
      o4n_c[e] = !o4z_c[e] && (rn == (by < qy));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_en) begin
      s1_vld_r <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_flags_r <= job_flags;
      for (int e = 0; e < NUM_EDGES; e++) begin
        p1_r[e] <= p1_c[e];
        p2_r[e] <= p2_c[e];
        pq_r[e] <= pq_c[e];
      end
      wq_r  <= wq_c;
      wd_r  <= wd_c;
      wa_r  <= wa_c;
      wb_r  <= wb_c;
      o3z_r <= o3z_c;
      o3n_r <= o3n_c;
      o4z_r <= o4z_c;
      o4n_r <= o4n_c;
    end
  end

  // Stage 2: signs, segment intersection, parity and on-edge decision
  always_comb begin
    for (int e = 0; e < NUM_EDGES; e++) begin
      d1     = SW'(p1_r[e]) - SW'(pq_r[e]);
      d2     = SW'(p2_r[e]) - SW'(pq_r[e]);
      o1z[e] = (d1 == '0);
      o1n[e] = d1[SW-1];
      o2z[e] = (d2 == '0);
      o2n[e] = d2[SW-1];
      meet[e] = (((o1z[e] != o2z[e]) || (o1n[e] != o2n[e])) &&
                 ((o3z_r[e] != o4z_r[e]) || (o3n_r[e] != o4n_r[e]))) ||
                (o1z[e] && wq_r[e]) || (o2z[e] && wd_r[e]) ||
                (o3z_r[e] && wa_r[e]) || (o4z_r[e] && wb_r[e]);
    end
    dec = dec_r;
    val = val_r;
    par = par_r;
    // Edges in polygon order; the first collinear crossing settles the answer
    for (int e = 0; e < NUM_EDGES; e++) begin
      if (s1_flags_r.edge_vld[e] && !dec && meet[e]) begin
        if (o1z[e]) begin
          dec = 1'b1;
          val = wq_r[e];
        end else begin
          par = !par;
        end
      end
    end
  end

  // Polygon state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_r <= 1'b0;
      val_r <= 1'b0;
      par_r <= 1'b0;
    end else if (s2_fire) begin
      if (s1_flags_r.last) begin
        dec_r <= 1'b0;
        val_r <= 1'b0;
        par_r <= 1'b0;
      end else begin
        dec_r <= dec;
        val_r <= val;
        par_r <= par;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= s1_vld_r && s1_flags_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_inside_r  <= !s1_flags_r.too_few && (dec ? val : par);
      out_too_few_r <= s1_flags_r.too_few;
    end
  end

  assign res_valid   = out_vld_r;
  assign res_inside  = out_inside_r;
  assign res_too_few = out_too_few_r;

endmodule

/* hdl/pipc_chk.sv */
// Port-level checker for the point-in-polygon core, with its bind.
`include "point_in_polygon_crossing_core_macros.svh"

module pipc_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             in_tlast,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [pipc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import pipc_pkg::*;

  logic [3:0] pend_r;
  logic       last_acc, out_acc;

  assign last_acc = in_tvalid && in_tready && in_tlast;
  assign out_acc  = out_tvalid && out_tready;

  // Closing items accepted but not yet answered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (last_acc && !out_acc) begin
      pend_r <= pend_r + 4'd1;
    end else if (out_acc && !last_acc) begin
      pend_r <= pend_r - 4'd1;
    end
  end

  `PIPC_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")
  `PIPC_ASSERT(a_too_few_outside, out_tvalid && out_tdata[OUT_TOO_FEW_BIT] |-> !out_tdata[OUT_INSIDE_BIT], "short polygon reported inside")
  `PIPC_ASSERT(a_no_spurious, out_tvalid |-> pend_r != 4'd0, "result without a closing vertex")
  `PIPC_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind point_in_polygon_crossing_core pipc_chk u_pipc_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
